### design/tzs_pkg.sv
// Shared types and constants of the thermal zone selector.
// Holds the zone table entry layout, the sequencer states and the default table size.
// No dependencies; every other file of the block uses it.
`default_nettype none

package tzs_pkg;

	localparam int unsigned ZONE_ENTRIES_DEF = 8;

	localparam int unsigned TAG_W     = 16;
	localparam int unsigned CELSIUS_W = 9;
	localparam int unsigned SCORE_W   = 3;

	typedef struct packed {
		logic [TAG_W-1:0]            tag;
		logic signed [CELSIUS_W-1:0] first_reading;
		logic                        has_moved;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

### design/tzs_reading_if.sv
// Channel interfaces of the thermal zone selector: zone readings in, chosen zones out.
// Depends on tzs_pkg for the field widths.
`default_nettype none

interface tzs_reading_if;
	logic                                 valid;
	logic                                 ready;
	logic [tzs_pkg::TAG_W-1:0]            zone_tag;
	logic signed [tzs_pkg::CELSIUS_W-1:0] reading_celsius;
	logic                                 cpu_named;
	logic                                 sample_last;

	modport source (
		output valid, zone_tag, reading_celsius, cpu_named, sample_last,
		input  ready
	);
	modport sink (
		input  valid, zone_tag, reading_celsius, cpu_named, sample_last,
		output ready
	);
endinterface

interface tzs_choice_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [tzs_pkg::CELSIUS_W-1:0] chosen_celsius;
	logic [tzs_pkg::TAG_W-1:0]            chosen_tag;
	logic [tzs_pkg::SCORE_W-1:0]          chosen_score;

	modport source (
		output valid, chosen_celsius, chosen_tag, chosen_score,
		input  ready
	);
	modport sink (
		input  valid, chosen_celsius, chosen_tag, chosen_score,
		output ready
	);
endinterface

`default_nettype wire

### design/thermal_zone_selector_unit.sv
// Top level of the thermal zone selector.
// Depends on tzs_pkg, the channel interfaces, tzs_table and tzs_ctrl.
//
// The reading channel takes one zone reading per beat: tag, Celsius value, a CPU-name
// flag and a flag marking the last reading of a sample. The choice channel gives one
// beat per sample, on its last reading: the tag, Celsius value and score (4 if the zone
// moved since its first reading, plus 2 if CPU-named) of the best reading.
// The zone table sits in a single-port-read, single-port-write memory and is scanned one
// entry per cycle through its registered read port, from entry 0 to the last stored entry.
// Each reading goes through the table scan (skipped on an empty table, ended early at the
// matching entry) and the update step before the next reading can be taken.
// A last reading adds an emit step; its choice beat is valid the cycle after the output register loads.
// Only one reading is in work at a time; a waiting choice beat does not hold off new
// readings, only the emit step of the next sample while the receiver stalls.
// Reset clears the fill count, the best tracker and the output valid flag at once; the
// table contents need no clearing because only entries below the fill count are read.
`default_nettype none

module thermal_zone_selector_unit #(
	parameter int unsigned ZONE_ENTRIES = tzs_pkg::ZONE_ENTRIES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tzs_reading_if.sink  reading,
	tzs_choice_if.source choice
);

	localparam int unsigned IDX_W = (ZONE_ENTRIES > 1) ? $clog2(ZONE_ENTRIES) : 1;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	tzs_pkg::entry_t  rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	tzs_pkg::entry_t  wr_data;

	tzs_table #(
		.ENTRIES (ZONE_ENTRIES),
		.IDX_W   (IDX_W)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	tzs_ctrl #(
		.ENTRIES (ZONE_ENTRIES),
		.IDX_W   (IDX_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.reading (reading),
		.choice  (choice),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

`default_nettype wire

### design/tzs_table.sv
// Zone table memory: one write port and one read port with registered read data.
// Depends on tzs_pkg for the entry layout.
`default_nettype none

module tzs_table #(
	parameter int unsigned ENTRIES = tzs_pkg::ZONE_ENTRIES_DEF,
	parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 rd_en,
	input  wire logic [IDX_W-1:0]     rd_addr,
	output tzs_pkg::entry_t           rd_data,
	input  wire logic                 wr_en,
	input  wire logic [IDX_W-1:0]     wr_addr,
	input  wire tzs_pkg::entry_t      wr_data
);

	tzs_pkg::entry_t mem [ENTRIES];
	tzs_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### design/tzs_ctrl.sv
// Sequencer of the thermal zone selector: scans the zone table, updates it,
// keeps the best reading of the sample and drives the output register.
// Depends on tzs_pkg and on the channel interfaces; drives the tzs_table ports.
`default_nettype none

module tzs_ctrl #(
	parameter int unsigned ENTRIES = tzs_pkg::ZONE_ENTRIES_DEF,
	parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	tzs_reading_if.sink           reading,
	tzs_choice_if.source          choice,
	output logic                  rd_en,
	output logic [IDX_W-1:0]      rd_addr,
	input  wire tzs_pkg::entry_t  rd_data,
	output logic                  wr_en,
	output logic [IDX_W-1:0]      wr_addr,
	output tzs_pkg::entry_t       wr_data
);

	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

	tzs_pkg::state_t state_q, state_d;

	logic [tzs_pkg::TAG_W-1:0]            tag_q;
	logic signed [tzs_pkg::CELSIUS_W-1:0] reading_q;
	logic                                 cpu_q;
	logic                                 last_q;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic             issue_q;
	logic             pend_s1;
	logic [IDX_W-1:0] chk_idx_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	tzs_pkg::entry_t  hit_entry_q;

	logic                                 have_best_q;
	logic signed [tzs_pkg::CELSIUS_W-1:0] best_celsius_q;
	logic [tzs_pkg::TAG_W-1:0]            best_tag_q;
	logic [tzs_pkg::SCORE_W-1:0]          top_score_q;

	logic                                 out_valid_q;
	logic signed [tzs_pkg::CELSIUS_W-1:0] out_celsius_q;
	logic [tzs_pkg::TAG_W-1:0]            out_tag_q;
	logic [tzs_pkg::SCORE_W-1:0]          out_score_q;

	logic                        accept;
	logic                        hit;
	logic                        scan_done;
	logic [CNT_W-1:0]            last_cnt;
	logic [CNT_W-1:0]            next_issue;
	logic                        table_full;
	logic                        moved;
	logic [tzs_pkg::SCORE_W-1:0] score;
	logic                        take;
	logic                        out_load;

	assign accept     = reading.valid && reading.ready;
	assign last_cnt   = count_q - CNT_W'(1);
	assign next_issue = CNT_W'(idx_q) + CNT_W'(1);
	assign hit        = pend_s1 && (rd_data.tag == tag_q);
	assign scan_done  = pend_s1 && (hit || (chk_idx_s1 == last_cnt[IDX_W-1:0]));
	assign table_full = (count_q == CNT_W'(ENTRIES));

	assign moved = hit_q && (hit_entry_q.has_moved ||
		(hit_entry_q.first_reading != reading_q));
	assign score = {moved, cpu_q, 1'b0};
	assign take  = !have_best_q || (score > top_score_q) ||
		((score == top_score_q) && (reading_q > best_celsius_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tzs_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (count_q == '0) ? tzs_pkg::ST_UPDATE : tzs_pkg::ST_SCAN;
				end
			end
			tzs_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = tzs_pkg::ST_UPDATE;
				end
			end
			tzs_pkg::ST_UPDATE: begin
				state_d = last_q ? tzs_pkg::ST_EMIT : tzs_pkg::ST_IDLE;
			end
			tzs_pkg::ST_EMIT: begin
				if (out_load) begin
					state_d = tzs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tzs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		reading.ready = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = idx_q;
		wr_en         = 1'b0;
		wr_addr       = hit_idx_q;
		wr_data       = hit_entry_q;
		out_load      = 1'b0;
		unique case (state_q)
			tzs_pkg::ST_IDLE: begin
				reading.ready = 1'b1;
			end
			tzs_pkg::ST_SCAN: begin
				rd_en = issue_q && !scan_done;
			end
			tzs_pkg::ST_UPDATE: begin
				if (hit_q) begin
					wr_en             = 1'b1;
					wr_data.has_moved = moved;
				end else if (!table_full) begin
					wr_en                 = 1'b1;
					wr_addr               = count_q[IDX_W-1:0];
					wr_data.tag           = tag_q;
					wr_data.first_reading = reading_q;
					wr_data.has_moved     = 1'b0;
				end
			end
			tzs_pkg::ST_EMIT: begin
				out_load = !out_valid_q || choice.ready;
			end
			default: begin
				reading.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tzs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q     <= reading.zone_tag;
			reading_q <= reading.reading_celsius;
			cpu_q     <= reading.cpu_named;
			last_q    <= reading.sample_last;
		end
		if (scan_done) begin
			hit_idx_q   <= chk_idx_s1;
			hit_entry_q <= rd_data;
		end
		if (rd_en) begin
			chk_idx_s1 <= idx_q;
		end
		if (out_load) begin
			out_celsius_q <= best_celsius_q;
			out_tag_q     <= best_tag_q;
			out_score_q   <= top_score_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (accept) begin
				idx_q   <= '0;
				issue_q <= (count_q != '0);
				hit_q   <= 1'b0;
			end else if (scan_done) begin
				issue_q <= 1'b0;
				hit_q   <= hit;
			end else if (rd_en) begin
				idx_q   <= idx_q + IDX_W'(1);
				issue_q <= (next_issue < count_q);
			end
			if (state_q == tzs_pkg::ST_UPDATE && !hit_q && !table_full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q    <= 1'b0;
			best_celsius_q <= '0;
			best_tag_q     <= '0;
			top_score_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == tzs_pkg::ST_UPDATE && take) begin
				have_best_q    <= 1'b1;
				best_celsius_q <= reading_q;
				best_tag_q     <= tag_q;
				top_score_q    <= score;
			end else if (out_load) begin
				have_best_q    <= 1'b0;
				best_celsius_q <= '0;
				best_tag_q     <= '0;
				top_score_q    <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (choice.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign choice.valid          = out_valid_q;
	assign choice.chosen_celsius = out_celsius_q;
	assign choice.chosen_tag     = out_tag_q;
	assign choice.chosen_score   = out_score_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("zone table fill count beyond table size");

	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !hit_q) |-> !table_full)
		else $error("new zone written into a full table");

	a_beat_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tzs_pkg::ST_EMIT))
		else $error("choice beat raised outside the emit step");

	a_best_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> !have_best_q)
		else $error("best tracker not cleared after emit");

	a_no_read_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !pend_s1)
		else $error("stale table read pending at start of a scan");
`endif

endmodule

`default_nettype wire

### test/tzs_selector_checker.sv
// Checker of the thermal zone selector: watches the reading and choice channels,
// predicts each chosen zone from its own copy of the zone table and compares field by field.
// Depends on tzs_pkg and the channel interfaces tzs_reading_if and tzs_choice_if.
`timescale 1ns / 1ps

module tzs_selector_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	tzs_reading_if    reading,
	tzs_choice_if     choice,
	output int        fail_count,
	output int        pending,
	output int        reading_count,
	output int        choice_count
);

	localparam int ZN = tzs_pkg::ZONE_ENTRIES_DEF;
	localparam int TW = tzs_pkg::TAG_W;
	localparam int CW = tzs_pkg::CELSIUS_W;
	localparam int SW = tzs_pkg::SCORE_W;

	typedef struct packed {
		logic [CW-1:0] celsius;
		logic [TW-1:0] tag;
		logic [SW-1:0] score;
	} choice_t;

	logic                 zone_used [ZN];
	logic [TW-1:0]        zone_tag_mem [ZN];
	logic signed [CW-1:0] zone_first [ZN];
	logic                 zone_moved [ZN];

	logic                 best_valid;
	logic signed [CW-1:0] best_celsius;
	logic [TW-1:0]        best_tag;
	logic [SW-1:0]        top_score;

	choice_t expected_choices [$];
	choice_t want;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		fail_count++;
		$display("MISMATCH at %0t, choice beat %0d, %s: got %0d, expected %0d",
			$realtime, choice_count, what, got, exp_val);
	endtask

	task automatic note_reading(input logic [TW-1:0] tag,
			input logic signed [CW-1:0] celsius, input logic cpu, input logic last);
		logic          found;
		logic          moved;
		logic [SW-1:0] score;
		found = 1'b0;
		moved = 1'b0;
		for (int i = 0; i < ZN; i++) begin
			if (!found && zone_used[i] && zone_tag_mem[i] == tag) begin
				found = 1'b1;
				if (zone_first[i] != celsius)
					zone_moved[i] = 1'b1;
				moved = zone_moved[i];
			end
		end
		for (int i = 0; i < ZN; i++) begin
			if (!found && !zone_used[i]) begin
				found           = 1'b1;
				zone_used[i]    = 1'b1;
				zone_tag_mem[i] = tag;
				zone_first[i]   = celsius;
				zone_moved[i]   = 1'b0;
			end
		end
		score = (moved ? 3'd4 : 3'd0) + (cpu ? 3'd2 : 3'd0);
		if (!best_valid || score > top_score ||
				(score == top_score && celsius > best_celsius)) begin
			best_valid   = 1'b1;
			best_celsius = celsius;
			best_tag     = tag;
			top_score    = score;
		end
		if (last) begin
			expected_choices.push_back('{best_celsius, best_tag, top_score});
			best_valid   = 1'b0;
			best_celsius = '0;
			best_tag     = '0;
			top_score    = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ZN; i++) begin
				zone_used[i]  = 1'b0;
				zone_moved[i] = 1'b0;
			end
			best_valid    = 1'b0;
			best_celsius  = '0;
			best_tag      = '0;
			top_score     = '0;
			fail_count    = 0;
			pending       = 0;
			reading_count = 0;
			choice_count  = 0;
			expected_choices.delete();
		end else begin
			if (choice.valid && choice.ready) begin
				choice_count++;
				if (expected_choices.size() == 0) begin
					report_mismatch("choice beat with nothing expected", 0, 0);
				end else begin
					want = expected_choices.pop_front();
					if (choice.chosen_celsius !== want.celsius)
						report_mismatch("chosen_celsius", $signed(choice.chosen_celsius),
							$signed(want.celsius));
					if (choice.chosen_tag !== want.tag)
						report_mismatch("chosen_tag", choice.chosen_tag, want.tag);
					if (choice.chosen_score !== want.score)
						report_mismatch("chosen_score", choice.chosen_score, want.score);
				end
			end
			if (reading.valid && reading.ready) begin
				reading_count++;
				note_reading(reading.zone_tag, reading.reading_celsius, reading.cpu_named,
					reading.sample_last);
			end
			pending = expected_choices.size();
		end
	end

endmodule

### test/thermal_zone_selector_unit_tb.sv
// Testbench top of the thermal zone selector: drives zone readings and the choice ready,
// runs directed cases and random samples under several idling mixes, and gives the verdict.
// Depends on tzs_pkg, the channel interfaces, the block and tzs_selector_checker.
`timescale 1ns / 1ps

module thermal_zone_selector_unit_tb;

	localparam int TW = tzs_pkg::TAG_W;
	localparam int CW = tzs_pkg::CELSIUS_W;

	localparam logic [TW-1:0] POOL_TAGS [12] = '{
		16'h0000, 16'hFFFF, 16'h0101, 16'h0202, 16'h0303, 16'h0404,
		16'h0505, 16'h0606, 16'h0707, 16'hAAAA, 16'h5555, 16'h0808
	};
	localparam int POOL_FIRST [12] = '{-50, 200, 30, 31, 31, -256, 255, 0, 100, -1, -2, 42};

	logic clk;
	logic arst_n;
	int   send_pct;
	int   stall_pct;
	int   hold_left;
	int   fail_count;
	int   pending;
	int   reading_count;
	int   choice_count;

	tzs_reading_if reading_ch ();
	tzs_choice_if  choice_ch ();

	thermal_zone_selector_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.reading(reading_ch),
		.choice (choice_ch)
	);

	tzs_selector_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.reading      (reading_ch),
		.choice       (choice_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.reading_count(reading_count),
		.choice_count (choice_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		choice_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				choice_ch.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				choice_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_reading(input logic [TW-1:0] tag, input int celsius,
			input logic cpu, input logic last);
		while ($urandom_range(99) < send_pct) begin
			reading_ch.valid <= 1'b0;
			@(posedge clk);
		end
		reading_ch.valid           <= 1'b1;
		reading_ch.zone_tag        <= tag;
		reading_ch.reading_celsius <= CW'(celsius);
		reading_ch.cpu_named       <= cpu;
		reading_ch.sample_last     <= last;
		do
			@(posedge clk);
		while (!reading_ch.ready);
	endtask

	task automatic drain_choices();
		reading_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	function automatic int random_celsius();
		if ($urandom_range(99) < 80)
			return int'($urandom_range(250)) - 50;
		return int'($urandom_range(511)) - 256;
	endfunction

	task automatic run_samples(input int n_items);
		int            sent;
		int            len;
		int            idx;
		int            celsius;
		logic [TW-1:0] tag;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(6, 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 70) begin
					idx     = $urandom_range(11);
					tag     = POOL_TAGS[idx];
					celsius = ($urandom_range(99) < 85) ? POOL_FIRST[idx] : random_celsius();
				end else begin
					tag     = TW'($urandom);
					celsius = random_celsius();
				end
				send_reading(tag, celsius, 1'($urandom_range(1)), i == len - 1);
				sent++;
			end
		end
	endtask

	task automatic run_phase(input int sp, input int rp, input int n_items);
		send_pct  = sp;
		stall_pct = rp;
		run_samples(n_items);
		drain_choices();
	endtask

	initial begin
		send_pct  = 0;
		stall_pct = 0;
		hold_left = 0;
		arst_n                     <= 1'b0;
		reading_ch.valid           <= 1'b0;
		reading_ch.zone_tag        <= '0;
		reading_ch.reading_celsius <= '0;
		reading_ch.cpu_named       <= 1'b0;
		reading_ch.sample_last     <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_reading(16'h0000, -50, 1'b0, 1'b1);
		send_reading(16'hFFFF, 200, 1'b1, 1'b0);
		send_reading(16'h0000, -50, 1'b0, 1'b1);
		send_reading(16'h0000, 17, 1'b0, 1'b1);
		send_reading(16'h0000, -50, 1'b1, 1'b0);
		send_reading(16'hFFFF, 200, 1'b1, 1'b1);
		send_reading(16'h0101, 30, 1'b0, 1'b0);
		send_reading(16'h0202, 31, 1'b0, 1'b0);
		send_reading(16'h0303, 31, 1'b0, 1'b1);
		send_reading(16'h0404, -256, 1'b0, 1'b0);
		send_reading(16'h0505, 255, 1'b0, 1'b1);
		send_reading(16'h0606, 0, 1'b1, 1'b0);
		send_reading(16'h0707, 100, 1'b1, 1'b0);
		send_reading(16'h0707, 101, 1'b1, 1'b1);
		send_reading(16'h0505, 254, 1'b0, 1'b1);
		send_reading(16'hAAAA, -1, 1'b1, 1'b0);
		send_reading(16'h5555, -2, 1'b0, 1'b1);
		drain_choices();

		run_phase(0, 0, 280);
		run_phase(86, 0, 280);
		run_phase(0, 86, 280);
		run_phase(24, 24, 280);

		send_pct  = 0;
		stall_pct = 0;
		hold_left = 400;
		run_samples(30);
		drain_choices();

		repeat (40) @(posedge clk);
		$display("Covered %0d zone readings and %0d chosen-zone beats under four idling mixes,",
			reading_count, choice_count);
		$display("a long receiver hold-off, and a zone table that filled and overflowed.");
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d chosen-zone beats still expected.", pending);
		$display("Some tests failed");
		$finish;
	end

endmodule
